// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LSS_ASSERT(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("assertion failed");
`define LSS_ASSERT_NEVER(lbl, clk_sig, rst_sig, cond) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) \
    else $error("forbidden condition seen");
`else
`define LSS_ASSERT(lbl, clk_sig, rst_sig, prop)
`define LSS_ASSERT_NEVER(lbl, clk_sig, rst_sig, cond)
`endif
`endif

// ===== rtl/core/lss_pkg.sv =====
package lss_pkg;

  localparam int CELLS    = 16;
  localparam int BYTE_W   = 8;
  localparam int PLEN_W   = 5;
  localparam int COUNT_W  = 21;
  localparam int OFFSET_W = 20;
  localparam int CFG_W    = 64;

  localparam logic [COUNT_W-1:0] MAX_TEXT_LENGTH = 21'd1048576;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW     = 2'd0,
    REG_PATTERN_HIGH    = 2'd1,
    REG_PATTERN_LENGTH  = 2'd2,
    REG_ZERO_TERMINATED = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/lss_ifs.sv =====
interface lss_text_if import lss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

interface lss_result_if import lss_pkg::*; ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [OFFSET_W-1:0] match_offset;

  modport source (output valid, status, match_offset, input ready);
  modport sink   (input valid, status, match_offset, output ready);
endinterface

interface lss_cfg_if import lss_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_reg_t         index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lss_cell.sv =====
module lss_cell import lss_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [BYTE_W-1:0] pat_byte,
  input  logic              pat_use,
  output logic [BYTE_W-1:0] byte_out,
  output logic              match
);

  // Compare the byte that moves in on this transfer.
  assign match = !pat_use || (byte_in == pat_byte);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      byte_out <= '0;
    end else if (ctrl.shift) begin
      byte_out <= byte_in;
    end
  end

endmodule

// ===== rtl/core/literal_substring_search_unit.sv =====
// A result is registered: it appears on the result channel in the cycle after the text byte that decides it.
// Throughput: one text byte per cycle; a 16-cell window chain compares all positions in parallel.
// A result stalled on the result channel holds off the next text byte until it transfers.
// Reset (rst, synchronous, active high): config registers, byte count, result flag, window
// cells and the output valid clear to zero; the window cells also clear at the end of every text.
`include "assert_macros.svh"

module literal_substring_search_unit import lss_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  lss_text_if.sink            text,
  lss_result_if.source        result,
  lss_cfg_if.sink             cfg
);

  // Configuration registers
  logic [CFG_W-1:0]  pattern_low;
  logic [CFG_W-1:0]  pattern_high;
  logic [PLEN_W-1:0] pattern_length;
  logic              zero_terminated;

  // Text state
  logic [COUNT_W-1:0] byte_count;
  logic               sent;

  // Output register
  logic                out_valid;
  status_t             out_status;
  logic [OFFSET_W-1:0] out_offset;

  // Pattern alignment
  logic [CELLS*BYTE_W-1:0] pat_all;
  logic [CELLS*BYTE_W-1:0] pat_aligned;
  logic [PLEN_W-1:0]       len;
  logic [PLEN_W-1:0]       eff;
  logic [PLEN_W-1:0]       shift;
  logic                    zero_seen;
  logic [CELLS-1:0]        pat_use;

  // Window chain
  logic [BYTE_W-1:0] cell_byte [CELLS];
  logic [CELLS-1:0]  cell_match;
  cell_ctrl_t        ctrl;

  // Step decision
  logic                in_xfer;
  logic [COUNT_W-1:0]  count_plus;
  logic                emit;
  logic                advance;
  status_t             status_next;
  logic [OFFSET_W-1:0] offset_next;

  // Config port: always ready, each write is taken in the cycle it is offered.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low     <= '0;
      pattern_high    <= '0;
      pattern_length  <= '0;
      zero_terminated <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PATTERN_LOW:     pattern_low     <= cfg.data;
        REG_PATTERN_HIGH:    pattern_high    <= cfg.data;
        REG_PATTERN_LENGTH:  pattern_length  <= cfg.data[PLEN_W-1:0];
        REG_ZERO_TERMINATED: zero_terminated <= cfg.data[0];
      endcase
    end
  end

  // Clamp the length, then cut it at the first zero pattern byte in terminated mode.
  assign pat_all = {pattern_high, pattern_low};
  assign len     = (pattern_length > PLEN_W'(CELLS)) ? PLEN_W'(CELLS) : pattern_length;

  always_comb begin
    eff       = len;
    zero_seen = 1'b0;
    for (int i = 0; i < CELLS; i++) begin
      if (!zero_seen && zero_terminated && (PLEN_W'(i) < len) &&
          (pat_all[i*BYTE_W +: BYTE_W] == '0)) begin
        eff       = PLEN_W'(i);
        zero_seen = 1'b1;
      end
    end
  end

  // Right-align the pattern so its last byte lines up with the newest window cell.
  assign shift       = PLEN_W'(CELLS) - eff;
  assign pat_aligned = pat_all << {shift, 3'b000};

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      pat_use[i] = (PLEN_W'(i) >= shift);
    end
  end

  // Window chain: cell CELLS-1 takes the new byte, each cell hands its byte down.
  assign in_xfer    = text.valid && text.ready;
  assign ctrl.clear = rst || (in_xfer && text.last_byte);
  assign ctrl.shift = in_xfer && advance;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    logic [BYTE_W-1:0] byte_in;
    if (g == CELLS - 1) begin : g_head
      assign byte_in = text.text_byte;
    end else begin : g_body
      assign byte_in = cell_byte[g+1];
    end

    lss_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .byte_in  (byte_in),
      .pat_byte (pat_aligned[g*BYTE_W +: BYTE_W]),
      .pat_use  (pat_use[g]),
      .byte_out (cell_byte[g]),
      .match    (cell_match[g])
    );
  end

  // Decide what this byte does. Once a text has its result, drop bytes until its end.
  assign count_plus = byte_count + COUNT_W'(1);

  always_comb begin
    emit        = 1'b0;
    advance     = 1'b0;
    status_next = STATUS_NOT_FOUND;
    offset_next = '0;
    if (!sent) begin
      priority if (zero_terminated && (len != '0) && (eff == '0)) begin
        // Pattern empty after the cut: found at the text start.
        emit        = 1'b1;
        status_next = STATUS_FOUND;
      end else if (zero_terminated && (text.text_byte == '0)) begin
        emit = 1'b1;
      end else if (byte_count >= MAX_TEXT_LENGTH) begin
        emit        = 1'b1;
        status_next = STATUS_TOO_LONG;
      end else begin
        advance = 1'b1;
        if ((eff != '0) && (count_plus >= COUNT_W'(eff)) && (&cell_match)) begin
          emit        = 1'b1;
          status_next = STATUS_FOUND;
          offset_next = count_plus[OFFSET_W-1:0] - OFFSET_W'(eff);
        end else if (text.last_byte) begin
          emit = 1'b1;
        end
      end
    end
  end

  // Text state: clear everything on the last byte, so the next byte starts fresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      sent       <= 1'b0;
    end else if (in_xfer) begin
      if (text.last_byte) begin
        byte_count <= '0;
        sent       <= 1'b0;
      end else begin
        if (emit) begin
          sent <= 1'b1;
        end
        if (advance) begin
          byte_count <= count_plus;
        end
      end
    end
  end

  // Output register: take a new byte whenever no result is held or the held result leaves in this cycle.
  assign text.ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      out_status <= status_next;
      out_offset <= offset_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.match_offset = out_offset;

  `LSS_ASSERT(a_count_bound, clk, rst, byte_count <= MAX_TEXT_LENGTH)
  `LSS_ASSERT_NEVER(a_emit_after_sent, clk, rst, in_xfer && emit && sent)
  `LSS_ASSERT(a_offset_zero, clk, rst, (out_valid && out_status != STATUS_FOUND) |-> (out_offset == '0))
  `LSS_ASSERT(a_last_clears, clk, rst, (in_xfer && text.last_byte) |=> (byte_count == '0 && !sent))

endmodule
